FILE: design/pbu_pkg.sv
`default_nettype none

package pbu_pkg;

  localparam int LEVELS     = 32;
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 32;
  localparam int SYM_BITS   = 16;

  typedef struct packed {
    logic                  vld;
    logic [PRICE_BITS-1:0] px;
    logic [QTY_BITS-1:0]   qty;
  } level_t;

  typedef struct packed {
    logic                  cmp_en;
    logic                  op_remove;
    logic                  op_overwrite;
    logic                  op_insert;
    logic [PRICE_BITS-1:0] px;
    logic [QTY_BITS-1:0]   qty;
  } cell_cmd_t;

  typedef struct packed {
    logic eq;
    logic goes;
  } cell_flag_t;

  typedef struct packed {
    logic top_chg;
    logic ovf;
  } side_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: design/pbu_cell.sv
`default_nettype none

module pbu_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               is_bid,
  input  pbu_pkg::cell_cmd_t cmd,
  input  pbu_pkg::level_t    prev_lvl,
  input  pbu_pkg::level_t    next_lvl,
  input  logic               prev_goes,
  output pbu_pkg::level_t    lvl,
  output pbu_pkg::cell_flag_t flag
);

  pbu_pkg::level_t lvl_next;
  logic            better;

  assign better = is_bid ? (cmd.px > lvl.px) : (cmd.px < lvl.px);

  always_comb begin
    lvl_next = lvl;
    if (cmd.op_remove) begin
      if (flag.eq || flag.goes) begin
        lvl_next = next_lvl;
      end
    end else if (cmd.op_overwrite) begin
      if (flag.eq) begin
        lvl_next.qty = cmd.qty;
      end
    end else if (cmd.op_insert) begin
      if (flag.goes && prev_goes) begin
        lvl_next = prev_lvl;
      end else if (flag.goes) begin
        lvl_next.vld = 1'b1;
        lvl_next.px  = cmd.px;
        lvl_next.qty = cmd.qty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl.vld <= 1'b0;
    end else begin
      lvl.vld <= lvl_next.vld;
    end
    lvl.px  <= lvl_next.px;
    lvl.qty <= lvl_next.qty;
    if (cmd.cmp_en) begin
      flag.eq   <= lvl.vld && (lvl.px == cmd.px);
      flag.goes <= !lvl.vld || better;
    end
  end

endmodule

`default_nettype wire

FILE: design/pbu_side.sv
`default_nettype none

module pbu_side (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           is_bid,
  input  logic                           cmp_en,
  input  logic                           upd_en,
  input  logic [pbu_pkg::PRICE_BITS-1:0] px,
  input  logic [pbu_pkg::QTY_BITS-1:0]   qty,
  output pbu_pkg::level_t                best,
  output pbu_pkg::side_status_t          status
);

  localparam int N = pbu_pkg::LEVELS;

  pbu_pkg::level_t     lvls [N];
  pbu_pkg::cell_flag_t flags [N];
  logic [N-1:0]        eq_vec;
  logic                hit;
  logic                qty_nz;
  pbu_pkg::cell_cmd_t  cmd;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      eq_vec[i] = flags[i].eq;
    end
  end

  assign hit    = |eq_vec;
  assign qty_nz = (qty != '0);

  always_comb begin
    cmd.cmp_en       = cmp_en;
    cmd.op_remove    = upd_en && !qty_nz && hit;
    cmd.op_overwrite = upd_en && qty_nz && hit;
    cmd.op_insert    = upd_en && qty_nz && !hit;
    cmd.px           = px;
    cmd.qty          = qty;
  end

  // best level after insert, overwrite or remove at the head of the side
  assign status.top_chg = flags[0].eq || (qty_nz && flags[0].goes);
  assign status.ovf     = qty_nz && !hit && lvls[N-1].vld;
  assign best           = lvls[0];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      pbu_pkg::level_t prev_l;
      pbu_pkg::level_t next_l;
      logic            prev_g;

      if (g == 0) begin : g_head
        assign prev_l = '0;
        assign prev_g = 1'b0;
      end else begin : g_body
        assign prev_l = lvls[g-1];
        assign prev_g = flags[g-1].goes;
      end

      if (g == N-1) begin : g_tail
        assign next_l = '0;
      end else begin : g_mid
        assign next_l = lvls[g+1];
      end

      pbu_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .is_bid    (is_bid),
        .cmd       (cmd),
        .prev_lvl  (prev_l),
        .next_lvl  (next_l),
        .prev_goes (prev_g),
        .lvl       (lvls[g]),
        .flag      (flags[g])
      );
    end
  endgenerate

endmodule

`default_nettype wire

FILE: design/price_level_book_update.sv
// Price-level book: bid and ask sides of 32 sorted levels each.
// Update channel (upd_valid / upd_stall): kind, price, quantity. A
// transaction is taken when upd_valid is high and upd_stall is low.
// Result channel (tob_valid / tob_stall): one top-of-book transaction per
// update, held stable while tob_stall is high.
// Config channel (cfg_valid / cfg_ready / cfg_data): symbol identifier,
// cfg_ready is always high; write only while no update is in flight.
// Each side is a chain of cells; every cell compares its level against
// the update in parallel, then takes the new level or its neighbour's.
// The result is registered after the compare, shift and output steps
// (ST_CMP, ST_UPD, ST_OUT), later if tob_stall holds the previous
// result. upd_stall stays high from capture through the output step, so
// a new update is not taken before the last one has passed them. The next
// update is taken while a result still waits on tob_stall.
// Reset (rst, synchronous): both sides empty, symbol zero, no result
// pending.
`default_nettype none

module price_level_book_update (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbu_pkg::SYM_BITS-1:0]   cfg_data,
  input  logic                           upd_valid,
  output logic                           upd_stall,
  input  logic                           kind,
  input  logic [pbu_pkg::PRICE_BITS-1:0] price,
  input  logic [pbu_pkg::QTY_BITS-1:0]   quantity,
  output logic                           tob_valid,
  input  logic                           tob_stall,
  output logic [pbu_pkg::SYM_BITS-1:0]   symbol,
  output logic                           top_changed,
  output logic                           bid_valid,
  output logic [pbu_pkg::PRICE_BITS-1:0] bid_price,
  output logic [pbu_pkg::QTY_BITS-1:0]   bid_quantity,
  output logic                           ask_valid,
  output logic [pbu_pkg::PRICE_BITS-1:0] ask_price,
  output logic [pbu_pkg::QTY_BITS-1:0]   ask_quantity,
  output logic                           overflow
);

  pbu_pkg::state_t              state;
  pbu_pkg::state_t              state_next;
  logic [pbu_pkg::SYM_BITS-1:0] symbol_id;
  logic                         sell;
  logic [pbu_pkg::PRICE_BITS-1:0] px;
  logic [pbu_pkg::QTY_BITS-1:0] qty;
  logic                         res_top;
  logic                         res_ovf;
  logic                         take;
  logic                         load_out;
  pbu_pkg::level_t              bid_best;
  pbu_pkg::level_t              ask_best;
  pbu_pkg::side_status_t        bid_status;
  pbu_pkg::side_status_t        ask_status;

  assign cfg_ready = 1'b1;
  assign upd_stall = (state != pbu_pkg::ST_IDLE);
  assign take      = upd_valid && !upd_stall;
  assign load_out  = (state == pbu_pkg::ST_OUT) && (!tob_valid || !tob_stall);

  always_comb begin
    state_next = state;
    case (state)
      pbu_pkg::ST_IDLE: if (take)     state_next = pbu_pkg::ST_CMP;
      pbu_pkg::ST_CMP:                state_next = pbu_pkg::ST_UPD;
      pbu_pkg::ST_UPD:                state_next = pbu_pkg::ST_OUT;
      pbu_pkg::ST_OUT:  if (load_out) state_next = pbu_pkg::ST_IDLE;
      default:                        state_next = pbu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pbu_pkg::ST_IDLE;
      symbol_id <= '0;
      tob_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        symbol_id <= cfg_data;
      end
      if (load_out) begin
        tob_valid <= 1'b1;
      end else if (!tob_stall) begin
        tob_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sell <= kind;
      px   <= price;
      qty  <= quantity;
    end
    if (state == pbu_pkg::ST_UPD) begin
      res_top <= sell ? ask_status.top_chg : bid_status.top_chg;
      res_ovf <= sell ? ask_status.ovf : bid_status.ovf;
    end
    if (load_out) begin
      symbol       <= symbol_id;
      top_changed  <= res_top;
      overflow     <= res_ovf;
      bid_valid    <= bid_best.vld;
      bid_price    <= bid_best.vld ? bid_best.px : '0;
      bid_quantity <= bid_best.vld ? bid_best.qty : '0;
      ask_valid    <= ask_best.vld;
      ask_price    <= ask_best.vld ? ask_best.px : '0;
      ask_quantity <= ask_best.vld ? ask_best.qty : '0;
    end
  end

  pbu_side u_bid (
    .clk    (clk),
    .rst    (rst),
    .is_bid (1'b1),
    .cmp_en ((state == pbu_pkg::ST_CMP) && !sell),
    .upd_en ((state == pbu_pkg::ST_UPD) && !sell),
    .px     (px),
    .qty    (qty),
    .best   (bid_best),
    .status (bid_status)
  );

  pbu_side u_ask (
    .clk    (clk),
    .rst    (rst),
    .is_bid (1'b0),
    .cmp_en ((state == pbu_pkg::ST_CMP) && sell),
    .upd_en ((state == pbu_pkg::ST_UPD) && sell),
    .px     (px),
    .qty    (qty),
    .best   (ask_best),
    .status (ask_status)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;

  localparam bit SIDE_BID = 1'b0;
  localparam bit SIDE_ASK = 1'b1;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [pbu_pkg::SYM_BITS-1:0]   symbol;
    logic                           top_changed;
    logic                           bid_valid;
    logic [pbu_pkg::PRICE_BITS-1:0] bid_price;
    logic [pbu_pkg::QTY_BITS-1:0]   bid_quantity;
    logic                           ask_valid;
    logic [pbu_pkg::PRICE_BITS-1:0] ask_price;
    logic [pbu_pkg::QTY_BITS-1:0]   ask_quantity;
    logic                           overflow;
  } tob_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pbu_pkg::SYM_BITS-1:0]   cfg_data = '0;
  logic                           upd_valid = 1'b0;
  logic                           upd_stall;
  logic                           kind = 1'b0;
  logic [pbu_pkg::PRICE_BITS-1:0] price = '0;
  logic [pbu_pkg::QTY_BITS-1:0]   quantity = '0;
  logic                           tob_valid;
  logic                           tob_stall = 1'b0;
  logic [pbu_pkg::SYM_BITS-1:0]   symbol;
  logic                           top_changed;
  logic                           bid_valid;
  logic [pbu_pkg::PRICE_BITS-1:0] bid_price;
  logic [pbu_pkg::QTY_BITS-1:0]   bid_quantity;
  logic                           ask_valid;
  logic [pbu_pkg::PRICE_BITS-1:0] ask_price;
  logic [pbu_pkg::QTY_BITS-1:0]   ask_quantity;
  logic                           overflow;

  price_level_book_update dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .upd_valid    (upd_valid),
    .upd_stall    (upd_stall),
    .kind         (kind),
    .price        (price),
    .quantity     (quantity),
    .tob_valid    (tob_valid),
    .tob_stall    (tob_stall),
    .symbol       (symbol),
    .top_changed  (top_changed),
    .bid_valid    (bid_valid),
    .bid_price    (bid_price),
    .bid_quantity (bid_quantity),
    .ask_valid    (ask_valid),
    .ask_price    (ask_price),
    .ask_quantity (ask_quantity),
    .overflow     (overflow)
  );

  // book mirror, indexed by side
  logic [pbu_pkg::PRICE_BITS-1:0] book_px  [2][pbu_pkg::LEVELS];
  logic [pbu_pkg::QTY_BITS-1:0]   book_qty [2][pbu_pkg::LEVELS];
  int                             book_cnt [2];
  logic [pbu_pkg::SYM_BITS-1:0]   symbol_reg;
  tob_t                           tob_expect_q[$];
  int                             mismatches;
  bit                             quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("price_level_book_update: mismatch");
    $finish;
  end

  function automatic void apply_level_update(input bit sd,
                                             input logic [pbu_pkg::PRICE_BITS-1:0] px,
                                             input logic [pbu_pkg::QTY_BITS-1:0] q,
                                             output bit top, output bit ovf);
    int n, hit, pos;
    bit drop_new;
    n = book_cnt[sd];
    hit = n;
    pos = n;
    drop_new = 1'b0;
    top = 1'b0;
    ovf = 1'b0;
    for (int i = 0; i < n; i++)
      if (hit == n && book_px[sd][i] == px) hit = i;
    if (q == '0) begin
      if (hit != n) begin
        for (int i = hit; i + 1 < n; i++) begin
          book_px[sd][i]  = book_px[sd][i+1];
          book_qty[sd][i] = book_qty[sd][i+1];
        end
        book_cnt[sd] = n - 1;
        top = (hit == 0);
      end
    end else if (hit != n) begin
      book_qty[sd][hit] = q;
      top = (hit == 0);
    end else begin
      for (int i = 0; i < n; i++)
        if (pos == n && (sd == SIDE_BID ? px > book_px[sd][i] : px < book_px[sd][i]))
          pos = i;
      if (n >= pbu_pkg::LEVELS) begin
        ovf = 1'b1;
        drop_new = (pos >= n);
        n = pbu_pkg::LEVELS - 1;
      end
      if (!drop_new) begin
        for (int i = n; i > pos; i--) begin
          book_px[sd][i]  = book_px[sd][i-1];
          book_qty[sd][i] = book_qty[sd][i-1];
        end
        book_px[sd][pos]  = px;
        book_qty[sd][pos] = q;
        book_cnt[sd] = n + 1;
        top = (pos == 0);
      end
    end
  endfunction

  function automatic void predict_update(input bit k,
                                         input logic [pbu_pkg::PRICE_BITS-1:0] px,
                                         input logic [pbu_pkg::QTY_BITS-1:0] q);
    bit top, ovf;
    tob_t t;
    apply_level_update(k, px, q, top, ovf);
    t.symbol       = symbol_reg;
    t.top_changed  = top;
    t.overflow     = ovf;
    t.bid_valid    = (book_cnt[SIDE_BID] > 0);
    t.bid_price    = t.bid_valid ? book_px[SIDE_BID][0] : '0;
    t.bid_quantity = t.bid_valid ? book_qty[SIDE_BID][0] : '0;
    t.ask_valid    = (book_cnt[SIDE_ASK] > 0);
    t.ask_price    = t.ask_valid ? book_px[SIDE_ASK][0] : '0;
    t.ask_quantity = t.ask_valid ? book_qty[SIDE_ASK][0] : '0;
    tob_expect_q.push_back(t);
  endfunction

  function automatic void check_tob();
    tob_t got, want;
    got = '{symbol, top_changed, bid_valid, bid_price, bid_quantity,
            ask_valid, ask_price, ask_quantity, overflow};
    if (tob_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("unexpected top-of-book transaction: %p", got);
      return;
    end
    want = tob_expect_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("tob mismatch: sym %h/%h chg %b/%b ovf %b/%b", want.symbol, got.symbol,
                 want.top_changed, got.top_changed, want.overflow, got.overflow);
        $display("  bid %b %h %h / %b %h %h", want.bid_valid, want.bid_price,
                 want.bid_quantity, got.bid_valid, got.bid_price, got.bid_quantity);
        $display("  ask %b %h %h / %b %h %h", want.ask_valid, want.ask_price,
                 want.ask_quantity, got.ask_valid, got.ask_price, got.ask_quantity);
      end
    end
  endfunction

  // result sink: random stall after each accepted transaction
  initial begin : tob_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && tob_valid && !tob_stall) begin
        check_tob();
        hold = quiet ? 0 : $urandom_range(0, 17);
      end
      tob_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  task automatic send_update(input bit k, input logic [pbu_pkg::PRICE_BITS-1:0] px,
                             input logic [pbu_pkg::QTY_BITS-1:0] q);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      upd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    upd_valid <= 1'b1;
    kind      <= k;
    price     <= px;
    quantity  <= q;
    do @(posedge clk); while (upd_stall);
    predict_update(k, px, q);
  endtask

  task automatic drain_book();
    upd_valid <= 1'b0;
    while (tob_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_symbol(input logic [pbu_pkg::SYM_BITS-1:0] v);
    drain_book();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    symbol_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // window 0: prices drawn over the full range
  task automatic run_churn(input int items, input int window, input int remove_pct,
                           input bit vary_idle);
    logic [pbu_pkg::PRICE_BITS-1:0] base, px;
    logic [pbu_pkg::QTY_BITS-1:0]   q;
    base = $urandom;
    for (int i = 0; i < items; i++) begin
      if (vary_idle && i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < remove_pct) q = '0;
      else if ($urandom_range(0, 1)) q = $urandom;
      else q = $urandom_range(1, 1000);
      px = (window == 0) ? $urandom : base + $urandom_range(0, window - 1);
      send_update(1'($urandom_range(0, 1)), px, q);
    end
  endtask

  task automatic test_directed_cases();
    quiet = 1'b0;
    send_update(SIDE_BID, 32'd5, '0);            // remove on empty side
    send_update(SIDE_BID, 32'd100, '1);
    send_update(SIDE_BID, 32'd0, 32'd1);
    send_update(SIDE_BID, '1, 32'd7);
    send_update(SIDE_BID, 32'd100, 32'd9);
    send_update(SIDE_BID, '1, 32'h8000_0000);
    set_symbol('1);
    send_update(SIDE_ASK, '1, 32'd3);
    send_update(SIDE_ASK, 32'd0, '1);            // crossed book
    send_update(SIDE_ASK, 32'd50, 32'd2);
    send_update(SIDE_ASK, 32'd77, '0);           // missing price
    send_update(SIDE_ASK, 32'd0, '0);
    send_update(SIDE_ASK, 32'd50, '0);
    send_update(SIDE_ASK, '1, '0);
    send_update(SIDE_BID, 32'd100, '0);
    send_update(SIDE_BID, '1, '0);
    send_update(SIDE_BID, 32'd0, '0);
    send_update(SIDE_BID, 32'd0, '0);
  endtask

  task automatic test_side_capacity();
    logic [pbu_pkg::PRICE_BITS-1:0] base;
    bit sd;
    set_symbol(16'($urandom_range(1, 16'hFFFE)));
    for (int s = 0; s < 2; s++) begin
      sd = s[0];
      base = $urandom_range(1000, 32'hF000_0000);
      for (int i = 0; i < pbu_pkg::LEVELS; i++)
        send_update(sd, base + 2 * i, $urandom_range(1, 32'hFFFF_FFFF));
      send_update(sd, sd == SIDE_BID ? base - 2 : base + 100, 32'd11);   // would be worst
      send_update(sd, sd == SIDE_BID ? base + 100 : base - 2, 32'd12);   // new best
      send_update(sd, base + 31, 32'd13);                                 // mid-table
      send_update(sd, sd == SIDE_BID ? base + 100 : base - 2, $urandom);
      send_update(sd, sd == SIDE_BID ? base + 100 : base - 2, '0);
      send_update(sd, base + 33, 32'd14);
    end
    run_churn(300, 48, 20, 1'b1);
  endtask

  task automatic test_level_churn();
    set_symbol('0);
    run_churn(350, 12, 35, 1'b1);
  endtask

  task automatic test_wide_prices();
    set_symbol(16'd1);
    run_churn(200, 0, 10, 1'b1);
  endtask

  task automatic test_back_to_back();
    set_symbol(16'($urandom));
    quiet = 1'b1;
    run_churn(200, 40, 25, 1'b0);
  endtask

  initial begin
    mismatches = 0;
    symbol_reg = '0;
    quiet = 1'b0;
    book_cnt[SIDE_BID] = 0;
    book_cnt[SIDE_ASK] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_side_capacity();
    test_level_churn();
    test_wide_prices();
    test_back_to_back();
    drain_book();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("price_level_book_update: match");
    else
      $display("price_level_book_update: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
